### design/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants for the max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

  // width of the key ports, fixed regardless of stored key width
  localparam int unsigned PORT_KEY_W = 32;
  // widest stored key supported
  localparam int unsigned MAX_KEY_W  = 64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ACT_INSERT  = 1'b0,
    ACT_EXTRACT = 1'b1
  } action_e;

endpackage

### design/max_heap_priority_queue_unit.sv
// An insert sifts up, and an extract reads the root and the last entry and then
// sifts down; a dropped insert or an empty extract goes straight to its result.
// Throughput: one word at a time; the sift walks one heap level per cycle,
// bound by the two-read-port key store. A result waiting in the output
// register does not block acceptance of the next word.
// Reset clears the entry count and control; store contents stay undefined.
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap priority queue with insert and extract-max, backed by a
// synchronous key store, with a registered result stage.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [hpq_pkg::PORT_KEY_W-1:0]      key_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hpq_pkg::PORT_KEY_W-1:0]      key_out_o,
  output logic [1:0]                          status_o,
  output logic [$clog2(CAPACITY+1)-1:0]       count_out_o
);

  import hpq_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = $clog2(CAPACITY);

  logic                 seq_res_valid;
  logic                 seq_res_take;
  logic [KEY_WIDTH-1:0] seq_res_key;
  status_e              seq_res_status;
  logic [CNT_W-1:0]     seq_res_count;

  logic [KEY_WIDTH-1:0] key_ext;
  logic [MAX_KEY_W-1:0] wide_in;
  logic [MAX_KEY_W-1:0] wide_out;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]    raddr_a;
  logic [ADDR_W-1:0]    raddr_b;
  logic [KEY_WIDTH-1:0] rdata_a;
  logic [KEY_WIDTH-1:0] rdata_b;

  logic                 out_valid_q;
  logic [PORT_KEY_W-1:0] out_key_q;
  status_e              out_status_q;
  logic [CNT_W-1:0]     out_count_q;

  // fit port keys to the stored width and back
  always_comb begin
    wide_in = '0;
    wide_in[PORT_KEY_W-1:0] = key_in_i;
    key_ext = wide_in[KEY_WIDTH-1:0];
    wide_out = '0;
    wide_out[KEY_WIDTH-1:0] = seq_res_key;
  end

  hpq_seq #(
    .CAPACITY (CAPACITY),
    .KEY_W    (KEY_WIDTH),
    .CNT_W    (CNT_W),
    .ADDR_W   (ADDR_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_ready_o  (in_ready_o),
    .action_i     (action_i),
    .key_i        (key_ext),
    .res_valid_o  (seq_res_valid),
    .res_take_i   (seq_res_take),
    .res_key_o    (seq_res_key),
    .res_status_o (seq_res_status),
    .res_count_o  (seq_res_count),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .rdata_a_i    (rdata_a),
    .rdata_b_i    (rdata_b)
  );

  hpq_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W),
    .DATA_W (KEY_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // load the result word when the output register is free or draining
  assign seq_res_take = seq_res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_take) begin
      out_key_q    <= wide_out[PORT_KEY_W-1:0];
      out_status_q <= seq_res_status;
      out_count_q  <= seq_res_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_out_o   = out_key_q;
  assign status_o    = out_status_q;
  assign count_out_o = out_count_q;

endmodule

### design/hpq_store.sv
// ----------------------------------------------------------------------------
// hpq_store
// Key store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hpq_store #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

### design/hpq_seq.sv
// ----------------------------------------------------------------------------
// hpq_seq
// Sift sequencer: keeps the entry count and the moving key, walks the heap
// one level a cycle through the key store.
// ----------------------------------------------------------------------------
module hpq_seq #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned KEY_W    = 32,
  parameter int unsigned CNT_W    = 11,
  parameter int unsigned ADDR_W   = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic                 action_i,
  input  logic [KEY_W-1:0]     key_i,
  // result
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output logic [KEY_W-1:0]     res_key_o,
  output hpq_pkg::status_e     res_status_o,
  output logic [CNT_W-1:0]     res_count_o,
  // store
  output logic                 we_o,
  output logic [ADDR_W-1:0]    waddr_o,
  output logic [KEY_W-1:0]     wdata_o,
  output logic [ADDR_W-1:0]    raddr_a_o,
  output logic [ADDR_W-1:0]    raddr_b_o,
  input  logic [KEY_W-1:0]     rdata_a_i,
  input  logic [KEY_W-1:0]     rdata_b_i
);

  import hpq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_ST  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_EX_RD  = 8'b0000_1000,
    S_EX_LD  = 8'b0001_0000,
    S_DN_CMP = 8'b0010_0000,
    S_WR     = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0] kout_q, kout_d;
  status_e          status_q, status_d;

  logic [CNT_W:0]   c_left;
  logic [CNT_W:0]   n_ext;
  logic             pick_r;
  logic [CNT_W-1:0] c_sel;
  logic [KEY_W-1:0] c_val;
  logic [CNT_W:0]   c_next;
  logic [CNT_W-1:0] par;

  // slot numbers are 1-based, store addresses 0-based
  function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W:0] slot);
    logic [CNT_W:0] a;
    a = slot - 1'b1;
    return a[ADDR_W-1:0];
  endfunction

  assign c_left = {pos_q, 1'b0};
  assign n_ext  = {1'b0, count_q};
  assign pick_r = (c_left < n_ext) && (rdata_a_i < rdata_b_i);
  assign c_sel  = pick_r ? CNT_W'(c_left + 1'b1) : c_left[CNT_W-1:0];
  assign c_val  = pick_r ? rdata_b_i : rdata_a_i;
  assign c_next = {c_sel, 1'b0};
  assign par    = pos_q >> 1;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    count_d   = count_q;
    key_d     = key_q;
    kout_d    = kout_q;
    status_d  = status_q;
    we_o      = 1'b0;
    waddr_o   = '0;
    wdata_o   = key_q;
    raddr_a_o = '0;
    raddr_b_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          kout_d   = '0;
          status_d = ST_OK;
          key_d    = key_i;
          if (action_i == ACT_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              count_d = count_q + 1'b1;
              pos_d   = count_q + 1'b1;
              state_d = S_UP_ST;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              count_d = count_q - 1'b1;
              pos_d   = count_q;
              state_d = S_EX_RD;
            end
          end
        end
      end

      S_UP_ST: begin
        if (pos_q == CNT_W'(1)) begin
          we_o    = 1'b1;
          waddr_o = addr_of({1'b0, pos_q});
          state_d = S_DONE;
        end else begin
          raddr_a_o = addr_of({1'b0, par});
          state_d   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        // parent word is on port A
        we_o    = 1'b1;
        waddr_o = addr_of({1'b0, pos_q});
        if (rdata_a_i < key_q) begin
          wdata_o = rdata_a_i;
          pos_d   = par;
          if (par == CNT_W'(1)) begin
            state_d = S_WR;
          end else begin
            raddr_a_o = addr_of({1'b0, par >> 1});
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_EX_RD: begin
        raddr_a_o = addr_of((CNT_W+1)'(1));
        raddr_b_o = addr_of({1'b0, pos_q});
        state_d   = S_EX_LD;
      end

      S_EX_LD: begin
        kout_d = rdata_a_i;
        key_d  = rdata_b_i;
        pos_d  = CNT_W'(1);
        if (count_q == '0) begin
          state_d = S_DONE;
        end else if (count_q >= CNT_W'(2)) begin
          raddr_a_o = addr_of((CNT_W+1)'(2));
          raddr_b_o = addr_of((CNT_W+1)'(3));
          state_d   = S_DN_CMP;
        end else begin
          we_o    = 1'b1;
          waddr_o = addr_of((CNT_W+1)'(1));
          wdata_o = rdata_b_i;
          state_d = S_DONE;
        end
      end

      S_DN_CMP: begin
        // children on ports A and B, take the left one on a tie
        we_o    = 1'b1;
        waddr_o = addr_of({1'b0, pos_q});
        if (key_q < c_val) begin
          wdata_o = c_val;
          pos_d   = c_sel;
          if (c_next <= n_ext) begin
            raddr_a_o = addr_of(c_next);
            raddr_b_o = addr_of(c_next + 1'b1);
          end else begin
            state_d = S_WR;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_WR: begin
        we_o    = 1'b1;
        waddr_o = addr_of({1'b0, pos_q});
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    key_q    <= key_d;
    kout_q   <= kout_d;
    status_q <= status_d;
  end

  assign req_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_key_o    = kout_q;
  assign res_status_o = status_q;
  assign res_count_o  = count_q;

endmodule

### tb/hpq_checker.sv
// ----------------------------------------------------------------------------
// hpq_checker
// Watches both channels of the heap priority queue. It keeps its own heap to
// predict every result and compares each returned word field by field.
// ----------------------------------------------------------------------------
module hpq_checker #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           action_i,
  input  logic [hpq_pkg::PORT_KEY_W-1:0] key_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [hpq_pkg::PORT_KEY_W-1:0] key_out_i,
  input  logic [1:0]                     status_i,
  input  logic [CNT_W-1:0]               count_out_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    pending_o
);

  localparam int unsigned PKW = hpq_pkg::PORT_KEY_W;

  typedef struct packed {
    logic [PKW-1:0]    key;
    hpq_pkg::status_e  status;
    logic [CNT_W-1:0]  count;
  } heap_result_t;

  logic [KEY_WIDTH-1:0] heap_slots [1:CAPACITY];
  int unsigned          heap_fill;
  heap_result_t         awaited_q [$];

  function automatic heap_result_t apply_heap_op(hpq_pkg::action_e act,
                                                 logic [PKW-1:0] key);
    heap_result_t         res;
    int unsigned          pos;
    int unsigned          child;
    logic [KEY_WIDTH-1:0] tmp;
    res.key    = '0;
    res.status = hpq_pkg::ST_OK;
    if (act == hpq_pkg::ACT_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        res.status = hpq_pkg::ST_FULL;
      end else begin
        heap_fill++;
        heap_slots[heap_fill] = KEY_WIDTH'(key);
        pos = heap_fill;
        // sift up while the parent is strictly smaller
        while (pos > 1 && heap_slots[pos >> 1] < heap_slots[pos]) begin
          tmp                   = heap_slots[pos >> 1];
          heap_slots[pos >> 1]  = heap_slots[pos];
          heap_slots[pos]       = tmp;
          pos                   = pos >> 1;
        end
      end
    end else if (heap_fill == 0) begin
      res.status = hpq_pkg::ST_EMPTY;
    end else begin
      res.key       = PKW'(heap_slots[1]);
      heap_slots[1] = heap_slots[heap_fill];
      heap_fill--;
      pos   = 1;
      child = 2;
      // sift down, taking the left child on a tie
      while (child <= heap_fill) begin
        if (child < heap_fill && heap_slots[child] < heap_slots[child + 1]) child++;
        if (!(heap_slots[pos] < heap_slots[child])) break;
        tmp               = heap_slots[pos];
        heap_slots[pos]   = heap_slots[child];
        heap_slots[child] = tmp;
        pos               = child;
        child             = pos << 1;
      end
    end
    res.count = CNT_W'(heap_fill);
    return res;
  endfunction

  task automatic note_mismatch(string what, heap_result_t want);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("%0t %s: key exp %h got %h, status exp %0d got %0d, count exp %0d got %0d",
               $time, what, want.key, key_out_i, want.status, status_i,
               want.count, count_out_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    if (!rst_ni) begin
      heap_fill = 0;
      awaited_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // check the returned word before queueing the new one
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          note_mismatch("unexpected word", '0);
        end else begin
          want = awaited_q.pop_front();
          if (key_out_i !== want.key || status_i !== want.status ||
              count_out_i !== want.count) begin
            note_mismatch("mismatch", want);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_q.push_back(apply_heap_op(hpq_pkg::action_e'(action_i), key_in_i));
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and extract words into the heap priority queue with random
// gaps and output stalls: a short directed pass, random traffic on a small
// heap, a fill to capacity with overflow, then a drain. The checker does the
// comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned PKW       = hpq_pkg::PORT_KEY_W;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic             action    = hpq_pkg::ACT_INSERT;
  logic [PKW-1:0]   key_in    = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PKW-1:0]   key_out;
  logic [1:0]       status;
  logic [CNT_W-1:0] count_out;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned occupancy = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  always #4 clk_i = ~clk_i;

  max_heap_priority_queue_unit #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .key_in_i    (key_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .key_out_o   (key_out),
    .status_o    (status),
    .count_out_o (count_out)
  );

  hpq_checker #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .key_in_i     (key_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .key_out_i    (key_out),
    .status_i     (status),
    .count_out_i  (count_out),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // mostly no gap, sometimes a short one, now and then a long one
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // bias towards tiny values so that equal keys meet in the heap
  function automatic logic [PKW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return PKW'($urandom_range(0, 7));
    if (r == 3) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return $urandom;
  endfunction

  function automatic hpq_pkg::action_e pick_action(int unsigned extract_pct);
    return ($urandom_range(0, 99) < extract_pct) ? hpq_pkg::ACT_EXTRACT
                                                 : hpq_pkg::ACT_INSERT;
  endfunction

  always @(posedge clk_i) begin
    int unsigned g;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      g = pick_gap(calm);
      if (g != 0) begin
        stall_left <= g - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // hold the word until taken, then sometimes idle for a while
  task automatic send_word(hpq_pkg::action_e act, logic [PKW-1:0] key);
    int unsigned gap;
    in_valid <= 1'b1;
    action   <= act;
    key_in   <= key;
    do @(posedge clk_i); while (!in_ready);
    if (act == hpq_pkg::ACT_INSERT) begin
      if (occupancy < CAPACITY) occupancy++;
    end else if (occupancy > 0) begin
      occupancy--;
    end
    gap = pick_gap(calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_mix(int unsigned words, int unsigned extract_pct);
    for (int unsigned i = 0; i < words; i++) begin
      if (i % 64 == 0) calm <= ($urandom_range(0, 4) == 0);
      send_word(pick_action(extract_pct), pick_key());
    end
  endtask

  initial begin
    logic [PKW-1:0] edge_keys [9];
    int unsigned    n;
    edge_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0005,
                  32'h0000_0005};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty extract, extreme and equal keys, then drain past empty
    send_word(hpq_pkg::ACT_EXTRACT, 32'hA5A5_A5A5);
    foreach (edge_keys[i]) send_word(hpq_pkg::ACT_INSERT, edge_keys[i]);
    repeat (10) send_word(hpq_pkg::ACT_EXTRACT, $urandom);
    send_word(hpq_pkg::ACT_INSERT, 32'hFFFF_FFFF);
    send_word(hpq_pkg::ACT_EXTRACT, 32'h0);

    // small heap with frequent empty extracts
    run_mix(50, 45);

    // fill to capacity, mostly inserts
    n = 0;
    while (occupancy < CAPACITY) begin
      if (n % 64 == 0) calm <= ($urandom_range(0, 4) == 0);
      send_word(pick_action(5), pick_key());
      n++;
    end

    // overflow, then churn around the full mark
    repeat (12) send_word(hpq_pkg::ACT_INSERT, pick_key());
    run_mix(40, 50);

    // mostly extracts, draining part of the deep heap
    run_mix(80, 75);

    in_valid <= 1'b0;
    // let the checker queue the last word before waiting on it
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    repeat (1000000) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

endmodule
